// File: sv/mma_pkg.sv
// Package: shared constants, types and command codes of the Montgomery arithmetic unit.
`timescale 1ns / 1ps
package mma_pkg;

  localparam int WORD_W    = 32;
  localparam int WORDS     = 8;
  localparam int VAL_W     = WORD_W * WORDS;
  localparam int LIMB_W    = 64;
  localparam int HI_W      = WORD_W + 2;
  localparam int IDX_W     = $clog2(WORDS);
  localparam int BIT_W     = $clog2(VAL_W);
  localparam int CFG_IDX_W = 3;
  localparam int NP_W      = 32;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_DBL  = 4'd2,
    OP_TPL  = 4'd3,
    OP_NEG  = 4'd4,
    OP_MUL  = 4'd5,
    OP_SQR  = 4'd6,
    OP_FROM = 4'd7,
    OP_POW  = 4'd8
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_W0  = 3'd0,
    CFG_MOD_W1  = 3'd1,
    CFG_MOD_W2  = 3'd2,
    CFG_MOD_W3  = 3'd3,
    CFG_N_PRIME = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_ADDX,
    CMD_SUBB,
    CMD_SUB_OV,
    CMD_SUB_GE,
    CMD_TPL_PASS,
    CMD_ADDP_COND,
    CMD_NEG,
    CMD_ZERO,
    CMD_MUL_INIT,
    CMD_MUL_ACC,
    CMD_MUL_TOP,
    CMD_MUL_M,
    CMD_MUL_RED,
    CMD_MUL_SHIFT,
    CMD_MUL_FINAL
  } dp_cmd_e;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_R,
    SEL_ONE
  } sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD1,
    ST_OV,
    ST_SUB1,
    ST_SUB2,
    ST_TPL1,
    ST_TPL2,
    ST_TPL3,
    ST_TPL4,
    ST_GE,
    ST_MUL_ACC,
    ST_MUL_TOP,
    ST_MUL_M,
    ST_MUL_RED,
    ST_MUL_SHIFT,
    ST_MUL_FIN,
    ST_POW_SCAN,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                capture;
    dp_cmd_e             cmd;
    sel_e                xsel;
    sel_e                ysel;
    logic [IDX_W-1:0]    xidx;
    logic [IDX_W-1:0]    yidx;
    logic [BIT_W-1:0]    bit_idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic exp_bit;
  } dp_stat_t;

  typedef struct packed {
    logic [3:0]        req_type;
    logic [LIMB_W-1:0] a_0;
    logic [LIMB_W-1:0] a_1;
    logic [LIMB_W-1:0] a_2;
    logic [LIMB_W-1:0] a_3;
    logic [LIMB_W-1:0] b_0;
    logic [LIMB_W-1:0] b_1;
    logic [LIMB_W-1:0] b_2;
    logic [LIMB_W-1:0] b_3;
  } req_t;

  typedef struct packed {
    logic [LIMB_W-1:0] result_0;
    logic [LIMB_W-1:0] result_1;
    logic [LIMB_W-1:0] result_2;
    logic [LIMB_W-1:0] result_3;
  } res_t;

endpackage

// File: sv/mma_datapath.sv
// Datapath: operand registers, word multiplier, accumulator ring and wide add/compare unit.
`timescale 1ns / 1ps
module mma_datapath
  import mma_pkg::*;
(
  input  logic                 clk_i,
  input  dp_ctrl_t             ctrl_i,
  output dp_stat_t             stat_o,
  input  req_t                 req_i,
  input  logic [VAL_W-1:0]     modulus_i,
  input  logic [NP_W-1:0]      n_prime_i,
  output res_t                 result_o
);

  logic [VAL_W-1:0]             a_q, b_q, x_q, y_q, r_q;
  logic [WORDS-1:0][WORD_W-1:0] t_q;
  logic [HI_W-1:0]              hi_q;
  logic [WORD_W-1:0]            c_q, m_q;

  logic [VAL_W-1:0]   xv, yv, t_flat;
  logic [WORD_W-1:0]  x_word, y_word, p_word, mul_x, mul_y;
  logic [2*WORD_W-1:0] prod, mac;
  logic [VAL_W:0]     add_x, sub_b, sub_p, t_sub_p;
  logic [VAL_W-1:0]   add_p, neg_v;
  logic               a_zero;
  logic [HI_W-1:0]    hi_sum;

  always_comb begin
    case (ctrl_i.xsel)
      SEL_A:   xv = a_q;
      SEL_B:   xv = b_q;
      SEL_R:   xv = r_q;
      default: xv = VAL_W'(1);
    endcase
    case (ctrl_i.ysel)
      SEL_A:   yv = a_q;
      SEL_B:   yv = b_q;
      SEL_R:   yv = r_q;
      default: yv = VAL_W'(1);
    endcase
  end

  assign x_word = x_q[ctrl_i.xidx*WORD_W +: WORD_W];
  assign y_word = y_q[ctrl_i.yidx*WORD_W +: WORD_W];
  assign p_word = modulus_i[ctrl_i.yidx*WORD_W +: WORD_W];

  always_comb begin
    case (ctrl_i.cmd)
      CMD_MUL_ACC: begin
        mul_x = x_word;
        mul_y = y_word;
      end
      CMD_MUL_M: begin
        mul_x = t_q[0];
        mul_y = n_prime_i;
      end
      default: begin
        mul_x = m_q;
        mul_y = p_word;
      end
    endcase
  end

  assign prod    = mul_x * mul_y;
  assign mac     = prod + {{WORD_W{1'b0}}, t_q[0]} + {{WORD_W{1'b0}}, c_q};
  assign t_flat  = t_q;
  assign add_x   = {1'b0, r_q} + {1'b0, xv};
  assign sub_b   = {1'b0, r_q} - {1'b0, b_q};
  assign sub_p   = {1'b0, r_q} - {1'b0, modulus_i};
  assign t_sub_p = {1'b0, t_flat} - {1'b0, modulus_i};
  assign add_p   = r_q + modulus_i;
  assign neg_v   = modulus_i - a_q;
  assign a_zero  = (a_q == '0);
  assign hi_sum  = hi_q + HI_W'(c_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      a_q <= {req_i.a_3, req_i.a_2, req_i.a_1, req_i.a_0};
      b_q <= {req_i.b_3, req_i.b_2, req_i.b_1, req_i.b_0};
    end
    case (ctrl_i.cmd) inside
      CMD_LOAD: begin
        r_q  <= a_q;
        hi_q <= '0;
      end
      CMD_ADDX: begin
        r_q  <= add_x[VAL_W-1:0];
        hi_q <= hi_q + HI_W'(add_x[VAL_W]);
      end
      CMD_SUBB: begin
        r_q  <= sub_b[VAL_W-1:0];
        hi_q <= HI_W'(sub_b[VAL_W]);
      end
      CMD_SUB_OV: begin
        if (hi_q != '0 || !sub_p[VAL_W]) r_q <= sub_p[VAL_W-1:0];
      end
      CMD_SUB_GE: begin
        if (!sub_p[VAL_W]) r_q <= sub_p[VAL_W-1:0];
      end
      CMD_TPL_PASS: begin
        if (hi_q != '0) begin
          r_q  <= sub_p[VAL_W-1:0];
          hi_q <= hi_q - HI_W'(sub_p[VAL_W]);
        end
      end
      CMD_ADDP_COND: begin
        if (hi_q != '0 || !sub_p[VAL_W]) r_q <= add_p;
      end
      CMD_NEG: begin
        r_q <= a_zero ? '0 : neg_v;
      end
      CMD_ZERO: begin
        r_q <= '0;
      end
      CMD_MUL_INIT: begin
        x_q  <= xv;
        y_q  <= yv;
        t_q  <= '0;
        hi_q <= '0;
        c_q  <= '0;
      end
      CMD_MUL_ACC, CMD_MUL_RED: begin
        c_q                <= mac[2*WORD_W-1:WORD_W];
        t_q[WORDS-2:0]     <= t_q[WORDS-1:1];
        t_q[WORDS-1]       <= mac[WORD_W-1:0];
      end
      CMD_MUL_TOP: begin
        hi_q <= hi_sum;
        c_q  <= '0;
      end
      CMD_MUL_M: begin
        m_q <= prod[WORD_W-1:0];
      end
      CMD_MUL_SHIFT: begin
        t_q[WORDS-2:0] <= t_q[WORDS-1:1];
        t_q[WORDS-1]   <= hi_sum[WORD_W-1:0];
        hi_q           <= hi_sum >> WORD_W;
        c_q            <= '0;
      end
      CMD_MUL_FINAL: begin
        r_q <= (hi_q != '0 || !t_sub_p[VAL_W]) ? t_sub_p[VAL_W-1:0] : t_flat;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.exp_bit = b_q[ctrl_i.bit_idx];

  assign result_o.result_0 = r_q[0*LIMB_W +: LIMB_W];
  assign result_o.result_1 = r_q[1*LIMB_W +: LIMB_W];
  assign result_o.result_2 = r_q[2*LIMB_W +: LIMB_W];
  assign result_o.result_3 = r_q[3*LIMB_W +: LIMB_W];

endmodule

// File: sv/mma_ctrl.sv
// Controller: state machine that sequences the datapath for every opcode.
`timescale 1ns / 1ps
module mma_ctrl
  import mma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [3:0]  req_type_i,
  input  dp_stat_t    stat_i,
  output dp_ctrl_t    ctrl_o,
  output logic        busy_o,
  output logic        done_o
);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d;
  logic [BIT_W-1:0]  idx_q, idx_d;
  logic              pow_q, pow_d, sq_q, sq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_ADD;
      i_q     <= '0;
      j_q     <= '0;
      idx_q   <= '0;
      pow_q   <= 1'b0;
      sq_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      i_q     <= i_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
      pow_q   <= pow_d;
      sq_q    <= sq_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    i_d            = i_q;
    j_d            = j_q;
    idx_d          = idx_q;
    pow_d          = pow_q;
    sq_d           = sq_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.cmd     = CMD_NOP;
    ctrl_o.xsel    = SEL_A;
    ctrl_o.ysel    = SEL_B;
    ctrl_o.xidx    = i_q;
    ctrl_o.yidx    = j_q;
    ctrl_o.bit_idx = idx_q;
    busy_o         = (state_q != ST_IDLE);
    done_o         = (state_q == ST_DONE);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          op_d           = op_e'(req_type_i);
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        i_d   = '0;
        j_d   = '0;
        pow_d = 1'b0;
        case (op_q) inside
          OP_ADD, OP_DBL: begin
            ctrl_o.cmd = CMD_LOAD;
            state_d    = ST_ADD1;
          end
          OP_SUB: begin
            ctrl_o.cmd = CMD_LOAD;
            state_d    = ST_SUB1;
          end
          OP_TPL: begin
            ctrl_o.cmd = CMD_LOAD;
            state_d    = ST_TPL1;
          end
          OP_NEG: begin
            ctrl_o.cmd = CMD_NEG;
            state_d    = ST_DONE;
          end
          OP_MUL: begin
            ctrl_o.cmd = CMD_MUL_INIT;
            state_d    = ST_MUL_ACC;
          end
          OP_SQR: begin
            ctrl_o.cmd  = CMD_MUL_INIT;
            ctrl_o.ysel = SEL_A;
            state_d     = ST_MUL_ACC;
          end
          OP_FROM: begin
            ctrl_o.cmd  = CMD_MUL_INIT;
            ctrl_o.ysel = SEL_ONE;
            state_d     = ST_MUL_ACC;
          end
          OP_POW: begin
            pow_d   = 1'b1;
            idx_d   = BIT_W'(VAL_W - 1);
            state_d = ST_POW_SCAN;
          end
          default: begin
            ctrl_o.cmd = CMD_ZERO;
            state_d    = ST_DONE;
          end
        endcase
      end
      ST_ADD1: begin
        ctrl_o.cmd  = CMD_ADDX;
        ctrl_o.xsel = (op_q == OP_ADD) ? SEL_B : SEL_A;
        state_d     = ST_OV;
      end
      ST_OV: begin
        ctrl_o.cmd = CMD_SUB_OV;
        state_d    = ST_DONE;
      end
      ST_SUB1: begin
        ctrl_o.cmd = CMD_SUBB;
        state_d    = ST_SUB2;
      end
      ST_SUB2: begin
        ctrl_o.cmd = CMD_ADDP_COND;
        state_d    = ST_DONE;
      end
      ST_TPL1: begin
        ctrl_o.cmd  = CMD_ADDX;
        ctrl_o.xsel = SEL_A;
        state_d     = ST_TPL2;
      end
      ST_TPL2: begin
        ctrl_o.cmd  = CMD_ADDX;
        ctrl_o.xsel = SEL_A;
        state_d     = ST_TPL3;
      end
      ST_TPL3: begin
        ctrl_o.cmd = CMD_TPL_PASS;
        state_d    = ST_TPL4;
      end
      ST_TPL4: begin
        ctrl_o.cmd = CMD_TPL_PASS;
        state_d    = ST_GE;
      end
      ST_GE: begin
        ctrl_o.cmd = CMD_SUB_GE;
        state_d    = ST_DONE;
      end
      ST_MUL_ACC: begin
        ctrl_o.cmd = CMD_MUL_ACC;
        j_d        = j_q + 1'b1;
        if (j_q == IDX_W'(WORDS - 1)) state_d = ST_MUL_TOP;
      end
      ST_MUL_TOP: begin
        ctrl_o.cmd = CMD_MUL_TOP;
        state_d    = ST_MUL_M;
      end
      ST_MUL_M: begin
        ctrl_o.cmd = CMD_MUL_M;
        state_d    = ST_MUL_RED;
      end
      ST_MUL_RED: begin
        ctrl_o.cmd = CMD_MUL_RED;
        j_d        = j_q + 1'b1;
        if (j_q == IDX_W'(WORDS - 1)) state_d = ST_MUL_SHIFT;
      end
      ST_MUL_SHIFT: begin
        ctrl_o.cmd = CMD_MUL_SHIFT;
        if (i_q == IDX_W'(WORDS - 1)) begin
          state_d = ST_MUL_FIN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_MUL_ACC;
        end
      end
      ST_MUL_FIN: begin
        ctrl_o.cmd = CMD_MUL_FINAL;
        i_d        = '0;
        j_d        = '0;
        if (!pow_q) begin
          state_d = ST_DONE;
        end else if (sq_q && stat_i.exp_bit) begin
          state_d = ST_POW_MUL;
        end else if (idx_q == '0) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = ST_POW_SQ;
        end
      end
      ST_POW_SCAN: begin
        if (stat_i.exp_bit) begin
          ctrl_o.cmd = CMD_LOAD;
          if (idx_q == '0) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_POW_SQ;
          end
        end else if (idx_q == '0) begin
          ctrl_o.cmd = CMD_ZERO;
          state_d    = ST_DONE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_POW_SQ: begin
        ctrl_o.cmd  = CMD_MUL_INIT;
        ctrl_o.xsel = SEL_R;
        ctrl_o.ysel = SEL_R;
        sq_d        = 1'b1;
        state_d     = ST_MUL_ACC;
      end
      ST_POW_MUL: begin
        ctrl_o.cmd  = CMD_MUL_INIT;
        ctrl_o.xsel = SEL_R;
        ctrl_o.ysel = SEL_A;
        sq_d        = 1'b0;
        state_d     = ST_MUL_ACC;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_top_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_TOP || state_q == ST_MUL_SHIFT) |-> (j_q == '0))
    else $error("word counter not wrapped at end of inner pass");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_FIN) |-> (i_q == IDX_W'(WORDS - 1)))
    else $error("multiply finished before last outer word");

endmodule

// File: sv/montgomery_mod_arith_unit_256.sv
// Top level: configuration registers and the controller/datapath pair of the modular unit.
`timescale 1ns / 1ps
// Modular arithmetic unit for a 256-bit odd modulus P in Montgomery form (R = 2^256).
// Raise start_i while busy_o is low to hand over one item; the result is on result_o
// while done_o is high for exactly one cycle, and done_o cannot be held off, so capture
// it then. Add, double and sub end with one conditional subtract or add of P, triple
// with conditional subtracts of P; negate gives P - A (zero for A = 0), unused opcodes zero.
// Multiply, square and from-Montgomery use one shared 32x32 multiplier that
// runs 8 outer words of 19 steps each (8 multiply-accumulate, one carry fold, one
// quotient word, 8 reduction steps, one word shift), plus init, a final conditional
// subtract and the done state. Power scans the exponent one bit a cycle from the top
// and then spends one multiply per remaining bit plus one per set bit.
// Write P (four 64-bit limbs) and n_prime only while the unit is idle.
module montgomery_mod_arith_unit_256
  import mma_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  req_t                  req_i,
  output logic                  done_o,
  output res_t                  result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [LIMB_W-1:0]     cfg_data_i
);

  // Modulus limbs and the word constant, cleared by reset.
  logic [LIMB_W-1:0] mod_w0_q, mod_w1_q, mod_w2_q, mod_w3_q;
  logic [NP_W-1:0]   n_prime_q;
  logic [VAL_W-1:0]  modulus;

  dp_ctrl_t dp_ctrl;
  dp_stat_t dp_stat;

  // Decode the register index; indexes past the list drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_w0_q  <= '0;
      mod_w1_q  <= '0;
      mod_w2_q  <= '0;
      mod_w3_q  <= '0;
      n_prime_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MOD_W0:  mod_w0_q  <= cfg_data_i;
        CFG_MOD_W1:  mod_w1_q  <= cfg_data_i;
        CFG_MOD_W2:  mod_w2_q  <= cfg_data_i;
        CFG_MOD_W3:  mod_w3_q  <= cfg_data_i;
        CFG_N_PRIME: n_prime_q <= cfg_data_i[NP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign modulus = {mod_w3_q, mod_w2_q, mod_w1_q, mod_w0_q};

  // Sequencer: decides every step of the item.
  mma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_i.req_type),
    .stat_i     (dp_stat),
    .ctrl_o     (dp_ctrl),
    .busy_o     (busy_o),
    .done_o     (done_o)
  );

  // Datapath: holds operands, the accumulator and the result register.
  mma_datapath u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (dp_ctrl),
    .stat_o    (dp_stat),
    .req_i     (req_i),
    .modulus_i (modulus),
    .n_prime_i (n_prime_q),
    .result_o  (result_o)
  );

endmodule
